[rtl/wsqg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the wall shadow quad geometry datapath
package wsqg_pkg;

	// field widths
	localparam int COORD_W = 24;
	localparam int LEN_W   = 23;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MAG_W   = COORD_W;
	localparam int FAR_W   = COORD_W + 2;

	// square root cell chain
	localparam int SQ_W          = 62;
	localparam int SQ_STEPS      = 31;
	localparam int ROOT_W        = 31;
	localparam int SQRT_PRESHIFT = 12;

	// extrusion divider chain
	localparam int NUM_SHIFT = 6;
	localparam int NUM_W     = MAG_W + LEN_W + NUM_SHIFT;
	localparam int EX_Q_W    = 24;
	localparam int EX_REM_W  = 55;

	// foot ratio: normalize, divide, scale
	localparam int W2_W        = 49;
	localparam int NORM_W      = 33;
	localparam int NORM_STEPS  = W2_W - NORM_W;
	localparam int FT_Q_W      = 31;
	localparam int FT_REM_W    = 64;
	localparam int RATIO_SHIFT = 30;

	// stage counts of the two sub-pipelines
	localparam int FT_LAT = 3 + NORM_STEPS + FT_Q_W + 2;
	localparam int EX_LAT = 3 + SQ_STEPS + 1 + EX_Q_W + 1;

	localparam int RESET_LEN_UNITS = 64;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [FAR_W-1:0]   far_t;
	typedef logic [LEN_W-1:0]          len_t;

	typedef enum logic [1:0] {
		REG_LIGHT_X    = 2'd0,
		REG_LIGHT_Y    = 2'd1,
		REG_SHADOW_LEN = 2'd2
	} reg_idx_t;

	typedef struct packed {
		coord_t light_x;
		coord_t light_y;
		len_t   shadow_length;
	} cfg_t;

endpackage
`default_nettype wire

[rtl/wsqg_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// one step of the bit-by-bit integer square root
module wsqg_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [wsqg_pkg::SQ_W-1:0]  prev_rem,
	input  wire logic [wsqg_pkg::SQ_W-1:0]  prev_res,
	output logic      [wsqg_pkg::SQ_W-1:0]  rem_q,
	output logic      [wsqg_pkg::SQ_W-1:0]  res_q
);
	import wsqg_pkg::*;

	logic [SQ_W-1:0] bit_w;
	logic [SQ_W-1:0] trial;
	logic            fit;

	// trial subtract of res + bit
	always_comb begin
		bit_w = SQ_W'(1) << (2 * STEP);
		trial = prev_res + bit_w;
		fit   = prev_rem >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fit) begin
				rem_q <= prev_rem - trial;
				res_q <= (prev_res >> 1) + bit_w;
			end else begin
				rem_q <= prev_rem;
				res_q <= prev_res >> 1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/wsqg_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// one step of a restoring divider, quotient built msb first
module wsqg_div_cell #(
	parameter int REM_W = 55,
	parameter int DVS_W = 31,
	parameter int Q_W   = 24,
	parameter int STEP  = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [REM_W-1:0] prev_rem,
	input  wire logic [DVS_W-1:0] prev_dvs,
	input  wire logic [Q_W-1:0]   prev_quo,
	output logic      [REM_W-1:0] rem_q,
	output logic      [DVS_W-1:0] dvs_q,
	output logic      [Q_W-1:0]   quo_q
);
	logic [REM_W-1:0] shifted;
	logic             fit;

	// divisor aligned to this quotient bit
	always_comb begin
		shifted = REM_W'(prev_dvs) << STEP;
		fit     = prev_rem >= shifted;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= fit ? (prev_rem - shifted) : prev_rem;
			dvs_q <= prev_dvs;
			quo_q <= {prev_quo[Q_W-2:0], fit};
		end
	end

endmodule
`default_nettype wire

[rtl/wsqg_extrude.sv]
`timescale 1ns / 1ps
`default_nettype none
// pushes one point away from the light by the shadow length
module wsqg_extrude (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire wsqg_pkg::cfg_t   cfg,
	input  wire wsqg_pkg::coord_t base_x,
	input  wire wsqg_pkg::coord_t base_y,
	output wsqg_pkg::far_t        far_x_q,
	output wsqg_pkg::far_t        far_y_q
);
	import wsqg_pkg::*;

	localparam int SIDE_N = EX_LAT - 1;
	localparam int NUMQ_N = SQ_STEPS + 1;

	typedef struct packed {
		logic   neg_x;
		logic   neg_y;
		logic   zero;
		coord_t base_x;
		coord_t base_y;
	} ex_side_t;

	logic signed [DIFF_W-1:0] dx, dy;
	logic [DIFF_W-1:0]        mx, my;

	ex_side_t                 side_q [0:SIDE_N-1];
	logic [MAG_W-1:0]         ax_s1, ay_s1;
	logic [2*MAG_W-1:0]       sqx_s2, sqy_s2;
	logic [MAG_W+LEN_W-1:0]   pax_s2, pay_s2;
	logic [SQ_W-1:0]          v_s3;
	logic [NUM_W-1:0]         nx_q [0:NUMQ_N-1];
	logic [NUM_W-1:0]         ny_q [0:NUMQ_N-1];

	logic [SQ_W-1:0]          sq_rem [0:SQ_STEPS];
	logic [SQ_W-1:0]          sq_res [0:SQ_STEPS];
	logic [ROOT_W-1:0]        root;

	logic [EX_REM_W-1:0]      numx_s4, numy_s4;
	logic [ROOT_W-1:0]        dvs_s4;

	logic [EX_REM_W-1:0]      dx_rem [0:EX_Q_W];
	logic [ROOT_W-1:0]        dx_dvs [0:EX_Q_W];
	logic [EX_Q_W-1:0]        dx_quo [0:EX_Q_W];
	logic [EX_REM_W-1:0]      dy_rem [0:EX_Q_W];
	logic [ROOT_W-1:0]        dy_dvs [0:EX_Q_W];
	logic [EX_Q_W-1:0]        dy_quo [0:EX_Q_W];

	ex_side_t                 last;
	far_t                     qx, qy, offx, offy;

	// direction from light and its magnitudes
	always_comb begin
		dx = DIFF_W'(base_x) - DIFF_W'(cfg.light_x);
		dy = DIFF_W'(base_y) - DIFF_W'(cfg.light_y);
		mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
		my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
	end

	// front stages: magnitudes, squares and length products, root operand
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= mx[MAG_W-1:0];
			ay_s1  <= my[MAG_W-1:0];
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			pax_s2 <= ax_s1 * cfg.shadow_length;
			pay_s2 <= ay_s1 * cfg.shadow_length;
			v_s3   <= (SQ_W'(sqx_s2) + SQ_W'(sqy_s2)) << SQRT_PRESHIFT;
		end
	end

	// side data that rides along the chains
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= '{neg_x: dx[DIFF_W-1], neg_y: dy[DIFF_W-1],
				zero: (dx == '0) && (dy == '0), base_x: base_x, base_y: base_y};
			for (int i = 1; i < SIDE_N; i++) begin
				side_q[i] <= side_q[i-1];
			end
			nx_q[0] <= NUM_W'(pax_s2) << NUM_SHIFT;
			ny_q[0] <= NUM_W'(pay_s2) << NUM_SHIFT;
			for (int i = 1; i < NUMQ_N; i++) begin
				nx_q[i] <= nx_q[i-1];
				ny_q[i] <= ny_q[i-1];
			end
		end
	end

	// square root of the scaled squared length
	assign sq_rem[0] = v_s3;
	assign sq_res[0] = '0;
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		wsqg_sqrt_cell #(.STEP(SQ_STEPS - 1 - k)) u_cell (
			.clk      (clk),
			.en       (en),
			.prev_rem (sq_rem[k]),
			.prev_res (sq_res[k]),
			.rem_q    (sq_rem[k+1]),
			.res_q    (sq_res[k+1])
		);
	end
	assign root = sq_res[SQ_STEPS][ROOT_W-1:0];

	// rounded numerators
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s4 <= EX_REM_W'(nx_q[NUMQ_N-1]) + EX_REM_W'(root >> 1);
			numy_s4 <= EX_REM_W'(ny_q[NUMQ_N-1]) + EX_REM_W'(root >> 1);
			dvs_s4  <= root;
		end
	end

	// component divisions by the root
	assign dx_rem[0] = numx_s4;
	assign dx_dvs[0] = dvs_s4;
	assign dx_quo[0] = '0;
	assign dy_rem[0] = numy_s4;
	assign dy_dvs[0] = dvs_s4;
	assign dy_quo[0] = '0;
	for (genvar k = 0; k < EX_Q_W; k++) begin : g_div
		wsqg_div_cell #(.REM_W(EX_REM_W), .DVS_W(ROOT_W), .Q_W(EX_Q_W),
			.STEP(EX_Q_W - 1 - k)) u_x (
			.clk (clk), .en (en),
			.prev_rem (dx_rem[k]), .prev_dvs (dx_dvs[k]), .prev_quo (dx_quo[k]),
			.rem_q (dx_rem[k+1]), .dvs_q (dx_dvs[k+1]), .quo_q (dx_quo[k+1])
		);
		wsqg_div_cell #(.REM_W(EX_REM_W), .DVS_W(ROOT_W), .Q_W(EX_Q_W),
			.STEP(EX_Q_W - 1 - k)) u_y (
			.clk (clk), .en (en),
			.prev_rem (dy_rem[k]), .prev_dvs (dy_dvs[k]), .prev_quo (dy_quo[k]),
			.rem_q (dy_rem[k+1]), .dvs_q (dy_dvs[k+1]), .quo_q (dy_quo[k+1])
		);
	end

	// signed offsets, zero-length direction gives no offset
	always_comb begin
		last = side_q[SIDE_N-1];
		qx   = FAR_W'(dx_quo[EX_Q_W]);
		qy   = FAR_W'(dy_quo[EX_Q_W]);
		offx = last.zero ? '0 : (last.neg_x ? -qx : qx);
		offy = last.zero ? '0 : (last.neg_y ? -qy : qy);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			far_x_q <= FAR_W'(last.base_x) + offx;
			far_y_q <= FAR_W'(last.base_y) + offy;
		end
	end

endmodule
`default_nettype wire

[rtl/wsqg_foot.sv]
`timescale 1ns / 1ps
`default_nettype none
// projection of the light onto the wall and the on-wall test
module wsqg_foot (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire wsqg_pkg::cfg_t   cfg,
	input  wire wsqg_pkg::coord_t wall_start_x,
	input  wire wsqg_pkg::coord_t wall_start_y,
	input  wire wsqg_pkg::coord_t wall_end_x,
	input  wire wsqg_pkg::coord_t wall_end_y,
	output wsqg_pkg::coord_t      foot_x,
	output wsqg_pkg::coord_t      foot_y,
	output logic                  on_wall,
	output wsqg_pkg::coord_t      start_x,
	output wsqg_pkg::coord_t      start_y,
	output wsqg_pkg::coord_t      end_x,
	output wsqg_pkg::coord_t      end_y
);
	import wsqg_pkg::*;

	localparam int SIDE_N = FT_LAT;
	localparam int OW_N   = FT_LAT - 2;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int T_W    = PROD_W + 1;
	localparam int MX_W   = MAG_W + FT_Q_W;

	typedef struct packed {
		coord_t           sx;
		coord_t           sy;
		coord_t           ex;
		coord_t           ey;
		logic [MAG_W-1:0] awx;
		logic [MAG_W-1:0] awy;
		logic             neg_wx;
		logic             neg_wy;
	} ft_side_t;

	logic signed [DIFF_W-1:0] wx, wy;
	logic [DIFF_W-1:0]        mwx, mwy;
	ft_side_t                 side_q [0:SIDE_N-1];
	logic                     ow_q [0:OW_N-1];

	logic signed [DIFF_W-1:0] dlx_s1, dly_s1, wx_s1, wy_s1;
	logic signed [PROD_W-1:0] ptx_s2, pty_s2, wwx_s2, wwy_s2;
	logic signed [T_W-1:0]    t_sum, w_sum;
	logic                     on_now;
	logic [W2_W-1:0]          tu_s3, w_s3;

	logic [W2_W-1:0]          nt_q [0:NORM_STEPS-1];
	logic [W2_W-1:0]          nw_q [0:NORM_STEPS-1];

	logic [FT_REM_W-1:0]      fd_rem [0:FT_Q_W];
	logic [NORM_W-1:0]        fd_dvs [0:FT_Q_W];
	logic [FT_Q_W-1:0]        fd_quo [0:FT_Q_W];

	logic [MX_W-1:0]          mx_s4, my_s4;
	logic [MX_W:0]            rndx, rndy;
	logic signed [DIFF_W-1:0] stx, sty, px, py;
	ft_side_t                 mul_side;

	// wall vector and magnitudes
	always_comb begin
		wx  = DIFF_W'(wall_end_x) - DIFF_W'(wall_start_x);
		wy  = DIFF_W'(wall_end_y) - DIFF_W'(wall_start_y);
		mwx = wx[DIFF_W-1] ? DIFF_W'(-wx) : DIFF_W'(wx);
		mwy = wy[DIFF_W-1] ? DIFF_W'(-wy) : DIFF_W'(wy);
	end

	// dot products
	always_comb begin
		t_sum  = T_W'(ptx_s2) + T_W'(pty_s2);
		w_sum  = T_W'(wwx_s2) + T_W'(wwy_s2);
		on_now = (t_sum > 0) && (t_sum < w_sum);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dlx_s1 <= DIFF_W'(cfg.light_x) - DIFF_W'(wall_start_x);
			dly_s1 <= DIFF_W'(cfg.light_y) - DIFF_W'(wall_start_y);
			wx_s1  <= wx;
			wy_s1  <= wy;
			ptx_s2 <= dlx_s1 * wx_s1;
			pty_s2 <= dly_s1 * wy_s1;
			wwx_s2 <= wx_s1 * wx_s1;
			wwy_s2 <= wy_s1 * wy_s1;
			tu_s3  <= on_now ? t_sum[W2_W-1:0] : '0;
			w_s3   <= w_sum[W2_W-1:0];
		end
	end

	// side data and on-wall flag line
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= '{sx: wall_start_x, sy: wall_start_y,
				ex: wall_end_x, ey: wall_end_y,
				awx: mwx[MAG_W-1:0], awy: mwy[MAG_W-1:0],
				neg_wx: wx[DIFF_W-1], neg_wy: wy[DIFF_W-1]};
			for (int i = 1; i < SIDE_N; i++) begin
				side_q[i] <= side_q[i-1];
			end
			ow_q[0] <= on_now;
			for (int i = 1; i < OW_N; i++) begin
				ow_q[i] <= ow_q[i-1];
			end
		end
	end

	// normalize: shift t and w together one bit a stage until w fits
	always_ff @(posedge clk) begin
		if (en) begin
			if (w_s3[W2_W-1:NORM_W] != '0) begin
				nt_q[0] <= tu_s3 >> 1;
				nw_q[0] <= w_s3 >> 1;
			end else begin
				nt_q[0] <= tu_s3;
				nw_q[0] <= w_s3;
			end
			for (int i = 1; i < NORM_STEPS; i++) begin
				if (nw_q[i-1][W2_W-1:NORM_W] != '0) begin
					nt_q[i] <= nt_q[i-1] >> 1;
					nw_q[i] <= nw_q[i-1] >> 1;
				end else begin
					nt_q[i] <= nt_q[i-1];
					nw_q[i] <= nw_q[i-1];
				end
			end
		end
	end

	// ratio t / w as a 30 bit fraction
	assign fd_rem[0] = FT_REM_W'(nt_q[NORM_STEPS-1]) << RATIO_SHIFT;
	assign fd_dvs[0] = nw_q[NORM_STEPS-1][NORM_W-1:0];
	assign fd_quo[0] = '0;
	for (genvar k = 0; k < FT_Q_W; k++) begin : g_div
		wsqg_div_cell #(.REM_W(FT_REM_W), .DVS_W(NORM_W), .Q_W(FT_Q_W),
			.STEP(FT_Q_W - 1 - k)) u_cell (
			.clk (clk), .en (en),
			.prev_rem (fd_rem[k]), .prev_dvs (fd_dvs[k]), .prev_quo (fd_quo[k]),
			.rem_q (fd_rem[k+1]), .dvs_q (fd_dvs[k+1]), .quo_q (fd_quo[k+1])
		);
	end

	// scale the wall vector by the ratio, round, add to the start point
	always_comb begin
		mul_side = side_q[SIDE_N-2];
		rndx = (MX_W+1)'(mx_s4) + ((MX_W+1)'(1) << (RATIO_SHIFT - 1));
		rndy = (MX_W+1)'(my_s4) + ((MX_W+1)'(1) << (RATIO_SHIFT - 1));
		stx  = DIFF_W'(rndx >> RATIO_SHIFT);
		sty  = DIFF_W'(rndy >> RATIO_SHIFT);
		px   = DIFF_W'(mul_side.sx) + (mul_side.neg_wx ? -stx : stx);
		py   = DIFF_W'(mul_side.sy) + (mul_side.neg_wy ? -sty : sty);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4  <= side_q[SIDE_N-3].awx * fd_quo[FT_Q_W];
			my_s4  <= side_q[SIDE_N-3].awy * fd_quo[FT_Q_W];
			foot_x <= px[COORD_W-1:0];
			foot_y <= py[COORD_W-1:0];
		end
	end

	assign on_wall = ow_q[OW_N-1];
	assign start_x = side_q[SIDE_N-1].sx;
	assign start_y = side_q[SIDE_N-1].sy;
	assign end_x   = side_q[SIDE_N-1].ex;
	assign end_y   = side_q[SIDE_N-1].ey;

endmodule
`default_nettype wire

[rtl/wall_shadow_quad_geometry_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// wall shadow quad geometry: extruded far points of one wall per beat
//
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   wall_start_x/y, wall_end_x/y
// out       source     out_valid / out_stall far_start/mid/end_x/y, foot_on_wall
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// one wall enters every cycle while in_stall is low
// a result passes the foot normalize and divider (31 cells) chains, then the square
// root (31 cells) and divider (24 cells) chains of the extrusion
// reset clears valid bits and sets config registers to defaults only, no clearing pass
// out_stall holds the chain only while its last stage carries a result
module wall_shadow_quad_geometry_core #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire wsqg_pkg::coord_t wall_start_x,
	input  wire wsqg_pkg::coord_t wall_start_y,
	input  wire wsqg_pkg::coord_t wall_end_x,
	input  wire wsqg_pkg::coord_t wall_end_y,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output wsqg_pkg::coord_t      far_start_x,
	output wsqg_pkg::coord_t      far_start_y,
	output wsqg_pkg::coord_t      far_mid_x,
	output wsqg_pkg::coord_t      far_mid_y,
	output wsqg_pkg::coord_t      far_end_x,
	output wsqg_pkg::coord_t      far_end_y,
	output logic                  foot_on_wall,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire wsqg_pkg::coord_t cfg_data
);
	import wsqg_pkg::*;

	localparam int   PIPE_N    = FT_LAT + EX_LAT;
	localparam len_t LEN_RESET = LEN_W'(RESET_LEN_UNITS << FRAC_BITS);

	cfg_t   cfg_q;
	logic   v_q [0:PIPE_N-1];
	logic   ow_q [0:EX_LAT-1];
	logic   adv, out_load;

	coord_t ft_x, ft_y, st_x, st_y, en_x, en_y;
	logic   ft_on;
	far_t   fs_x, fs_y, fe_x, fe_y, fm_x, fm_y;

	logic signed [FAR_W:0] mean_x, mean_y, mid_x, mid_y;

	logic   out_valid_q;
	coord_t far_start_x_q, far_start_y_q, far_mid_x_q, far_mid_y_q;
	coord_t far_end_x_q, far_end_y_q;
	logic   foot_on_wall_q;

	function automatic coord_t sat_coord(input logic signed [FAR_W:0] v);
		logic [FAR_W-COORD_W+1:0] top;
		coord_t                   r;
		top = v[FAR_W:COORD_W-1];
		if (top == '0 || top == '1) begin
			r = v[COORD_W-1:0];
		end else if (v[FAR_W]) begin
			r = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{light_x: '0, light_y: '0, shadow_length: LEN_RESET};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIGHT_X:    cfg_q.light_x       <= cfg_data;
				REG_LIGHT_Y:    cfg_q.light_y       <= cfg_data;
				REG_SHADOW_LEN: cfg_q.shadow_length <= cfg_data[LEN_W-1:0];
				default:        cfg_q               <= cfg_q;
			endcase
		end
	end

	// flow control: chain moves unless a held result blocks its last stage
	assign out_load = !out_valid_q || !out_stall;
	assign adv      = out_load || !v_q[PIPE_N-1];
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_N; i++) begin
				v_q[i] <= 1'b0;
			end
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i < PIPE_N; i++) begin
				v_q[i] <= v_q[i-1];
			end
		end
	end

	wsqg_foot u_foot (
		.clk          (clk),
		.en           (adv),
		.cfg          (cfg_q),
		.wall_start_x (wall_start_x),
		.wall_start_y (wall_start_y),
		.wall_end_x   (wall_end_x),
		.wall_end_y   (wall_end_y),
		.foot_x       (ft_x),
		.foot_y       (ft_y),
		.on_wall      (ft_on),
		.start_x      (st_x),
		.start_y      (st_y),
		.end_x        (en_x),
		.end_y        (en_y)
	);

	wsqg_extrude u_ex_start (
		.clk (clk), .en (adv), .cfg (cfg_q),
		.base_x (st_x), .base_y (st_y), .far_x_q (fs_x), .far_y_q (fs_y)
	);

	wsqg_extrude u_ex_end (
		.clk (clk), .en (adv), .cfg (cfg_q),
		.base_x (en_x), .base_y (en_y), .far_x_q (fe_x), .far_y_q (fe_y)
	);

	wsqg_extrude u_ex_mid (
		.clk (clk), .en (adv), .cfg (cfg_q),
		.base_x (ft_x), .base_y (ft_y), .far_x_q (fm_x), .far_y_q (fm_y)
	);

	// on-wall flag alongside the extrusions
	always_ff @(posedge clk) begin
		if (adv) begin
			ow_q[0] <= ft_on;
			for (int i = 1; i < EX_LAT; i++) begin
				ow_q[i] <= ow_q[i-1];
			end
		end
	end

	// mean of far endpoints or extruded foot, then saturate
	always_comb begin
		mean_x = ((FAR_W+1)'(fs_x) + (FAR_W+1)'(fe_x)) >>> 1;
		mean_y = ((FAR_W+1)'(fs_y) + (FAR_W+1)'(fe_y)) >>> 1;
		mid_x  = ow_q[EX_LAT-1] ? (FAR_W+1)'(fm_x) : mean_x;
		mid_y  = ow_q[EX_LAT-1] ? (FAR_W+1)'(fm_y) : mean_y;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= v_q[PIPE_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			far_start_x_q  <= sat_coord((FAR_W+1)'(fs_x));
			far_start_y_q  <= sat_coord((FAR_W+1)'(fs_y));
			far_end_x_q    <= sat_coord((FAR_W+1)'(fe_x));
			far_end_y_q    <= sat_coord((FAR_W+1)'(fe_y));
			far_mid_x_q    <= sat_coord(mid_x);
			far_mid_y_q    <= sat_coord(mid_y);
			foot_on_wall_q <= ow_q[EX_LAT-1];
		end
	end

	assign out_valid    = out_valid_q;
	assign far_start_x  = far_start_x_q;
	assign far_start_y  = far_start_y_q;
	assign far_mid_x    = far_mid_x_q;
	assign far_mid_y    = far_mid_y_q;
	assign far_end_x    = far_end_x_q;
	assign far_end_y    = far_end_y_q;
	assign foot_on_wall = foot_on_wall_q;

`ifndef NO_ASSERTIONS
	// input is held back only by a stalled, occupied output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && v_q[PIPE_N-1]))
		else $error("input stalled without a blocked result");

	// a blocked last stage keeps its item
	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && v_q[PIPE_N-1]) |=> v_q[PIPE_N-1])
		else $error("result lost from last stage while stalled");

	// an accepted beat enters the chain
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_q[0])
		else $error("accepted beat missing from first stage");
`endif

endmodule
`default_nettype wire
